// ===== src/bir_pkg.sv =====
// shared constants, types and helpers of the bilinear resize block
package bir_pkg;

  localparam int unsigned MAX_SOURCE_WIDTH  = 256;
  localparam int unsigned MAX_SOURCE_HEIGHT = 256;
  localparam int unsigned MAX_CHANNELS      = 4;
  localparam int unsigned FRACTION_BITS     = 16;

  localparam int unsigned POS_W      = 12;
  localparam int unsigned CH_BITS    = 8;
  localparam int unsigned SW_W       = 9;
  localparam int unsigned TW_W       = 13;
  localparam int unsigned CC_W       = 3;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 13;

  localparam int unsigned XW      = $clog2(MAX_SOURCE_WIDTH);
  localparam int unsigned YW      = $clog2(MAX_SOURCE_HEIGHT);
  localparam int unsigned COORD_W = (XW > YW) ? XW : YW;
  localparam int unsigned RATIO_W = COORD_W + FRACTION_BITS;
  localparam int unsigned VAL_W   = CH_BITS + FRACTION_BITS;
  localparam int unsigned OPA_W   = ((RATIO_W > VAL_W) ? RATIO_W : VAL_W) + 1;
  localparam int unsigned F_W     = (FRACTION_BITS > POS_W) ? FRACTION_BITS : POS_W;
  localparam int unsigned ACC_W   = OPA_W + F_W + 1;
  localparam int unsigned FL_W    = ACC_W - FRACTION_BITS;
  localparam int unsigned RND_W   = ACC_W - 2 * FRACTION_BITS;
  localparam int unsigned DIV_W   = TW_W;
  localparam int unsigned ADDR_W  = $clog2(MAX_SOURCE_WIDTH * MAX_SOURCE_HEIGHT);
  localparam int unsigned PIX_W   = MAX_CHANNELS * CH_BITS;
  localparam int unsigned CHI_W   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

  localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_WIDTH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_HEIGHT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT = 3'd4;

  localparam logic OP_WRITE   = 1'b0;
  localparam logic OP_REQUEST = 1'b1;

  typedef enum logic [4:0] {
    S_IDLE, S_DIVX, S_DIVY, S_MULX, S_MULY, S_SPLIT,
    S_RD0, S_RD1, S_RD2, S_RD3, S_RD4,
    S_H0, S_H1, S_V, S_VD, S_DONE
  } state_e;

  typedef struct packed {
    logic [COORD_W-1:0]       lo;
    logic [COORD_W-1:0]       hi;
    logic [FRACTION_BITS-1:0] frac;
  } split_t;

  // floor, ceil and fraction of a fixed-point coordinate, clamped to the image
  function automatic split_t split_coord(logic signed [ACC_W-1:0] pos, logic [SW_W-1:0] size);
    logic [FL_W-1:0]          fl;
    logic [FL_W-1:0]          ce;
    logic [FL_W-1:0]          lim;
    logic [FRACTION_BITS-1:0] fr;
    split_t                   s;
    fl  = pos[ACC_W-1:FRACTION_BITS];
    fr  = pos[FRACTION_BITS-1:0];
    ce  = fl + FL_W'(fr != '0);
    lim = FL_W'(size) - FL_W'(1);
    if (fl > lim) begin
      fl = lim;
      fr = '0;
    end
    if (ce > lim) begin
      ce = lim;
    end
    s.lo   = fl[COORD_W-1:0];
    s.hi   = ce[COORD_W-1:0];
    s.frac = fr;
    return s;
  endfunction

endpackage

// ===== src/bir_ram.sv =====
// generic single-port ram with registered read
module bir_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 65536
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end else begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/bir_div.sv =====
// restoring divider, one quotient bit per cycle, for the scale ratios
module bir_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [bir_pkg::RATIO_W-1:0] dividend_i,
  input  logic [bir_pkg::DIV_W-1:0]   divisor_i,
  output logic                        done_o,
  output logic [bir_pkg::RATIO_W-1:0] quot_o
);
  import bir_pkg::*;

  localparam int unsigned CNT_W = $clog2(RATIO_W + 1);

  logic [RATIO_W-1:0] quot_q, quot_d;
  logic [DIV_W-1:0]   rem_q, rem_d;
  logic [DIV_W-1:0]   div_q, div_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic               run_q, run_d;
  logic               done_q, done_d;
  logic [DIV_W:0]     part;
  logic [DIV_W:0]     trial;
  logic               ge;

  always_comb begin
    part   = {rem_q, quot_q[RATIO_W-1]};
    trial  = part - {1'b0, div_q};
    ge     = part >= {1'b0, div_q};
    quot_d = quot_q;
    rem_d  = rem_q;
    div_d  = div_q;
    cnt_d  = cnt_q;
    run_d  = run_q;
    done_d = 1'b0;
    if (start_i) begin
      quot_d = dividend_i;
      rem_d  = '0;
      div_d  = divisor_i;
      cnt_d  = CNT_W'(RATIO_W);
      run_d  = 1'b1;
    end else if (run_q) begin
      rem_d  = ge ? trial[DIV_W-1:0] : part[DIV_W-1:0];
      quot_d = {quot_q[RATIO_W-2:0], ge};
      cnt_d  = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    div_q  <= div_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

// ===== src/bir_mac.sv =====
// shared multiply-add: res = a * 2^frac + d * f, registered
module bir_mac (
  input  logic                             clk_i,
  input  logic                             en_i,
  input  logic signed [bir_pkg::OPA_W-1:0] a_i,
  input  logic signed [bir_pkg::OPA_W-1:0] d_i,
  input  logic        [bir_pkg::F_W-1:0]   f_i,
  output logic signed [bir_pkg::ACC_W-1:0] res_o
);
  import bir_pkg::*;

  logic signed [ACC_W-1:0] res_q, res_d;
  logic signed [ACC_W-1:0] a_ext;
  logic signed [ACC_W-1:0] prod;

  always_comb begin
    a_ext = {{(ACC_W - OPA_W){a_i[OPA_W-1]}}, a_i} <<< FRACTION_BITS;
    prod  = ACC_W'(d_i * $signed({1'b0, f_i}));
    res_d = a_ext + prod;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

endmodule

// ===== src/bilinear_image_resize.sv =====
// bilinear resize with aligned corners: source store, sequencer and output word
// Input channel: valid/stall; operation 0 writes one source pixel word into the
// source ram (row * MAX_SOURCE_WIDTH + column), operation 1 requests one
// destination pixel. Writes produce no output word.
// A request outside the destination image returns status 1.
// A request inside runs two multiplies for the source coordinates, four reads
// of the single-port source ram, then three passes of the shared multiply-add
// unit per channel. One item at a time.
// Output channel: valid/stall with an output register; the next item is taken
// while a finished word still waits. A stalled receiver holds the sequencer
// only once the next result is ready.
// Configuration writes take effect at once; the two scale ratios are then
// recomputed by a serial divider, during which the input is stalled. After
// reset the same recompute runs; the source ram is not cleared and pixels
// must be written before they are read.
module bilinear_image_resize (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [bir_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [bir_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          operation_i,
  input  logic [bir_pkg::POS_W-1:0]     pos_x_i,
  input  logic [bir_pkg::POS_W-1:0]     pos_y_i,
  input  logic [7:0]                    in_ch0_i,
  input  logic [7:0]                    in_ch1_i,
  input  logic [7:0]                    in_ch2_i,
  input  logic [7:0]                    in_ch3_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          status_o,
  output logic [7:0]                    out_ch0_o,
  output logic [7:0]                    out_ch1_o,
  output logic [7:0]                    out_ch2_o,
  output logic [7:0]                    out_ch3_o
);
  import bir_pkg::*;

  state_e state_q, state_d;

  logic [SW_W-1:0] sw_q, sh_q;
  logic [TW_W-1:0] tw_q, th_q;
  logic [CC_W-1:0] cc_q;
  logic            need_q, need_d;

  logic [RATIO_W-1:0] ratio_x_q, ratio_x_d, ratio_y_q, ratio_y_d;

  logic [SW_W-1:0] sw_eff, sh_eff;
  logic [CC_W-1:0] nch_eff;

  logic [POS_W-1:0] px_q, px_d, py_q, py_d;
  logic [COORD_W-1:0] left_q, left_d, right_q, right_d;
  logic [COORD_W-1:0] top_q, top_d, bot_q, bot_d;
  logic [FRACTION_BITS-1:0] fx_q, fx_d, fy_q, fy_d;
  logic [PIX_W-1:0] lt_q, lt_d, rt_q, rt_d, lb_q, lb_d, rb_q, rb_d;
  logic signed [OPA_W-1:0] tl_q, tl_d;
  logic [CHI_W-1:0] ch_q, ch_d;
  logic             stat_q, stat_d;
  logic [CH_BITS-1:0] res_ch_q [MAX_CHANNELS];
  logic [CH_BITS-1:0] res_ch_d [MAX_CHANNELS];

  logic               out_valid_q, out_valid_d;
  logic               out_stat_q, out_stat_d;
  logic [CH_BITS-1:0] out_ch_q [MAX_CHANNELS];
  logic [CH_BITS-1:0] out_ch_d [MAX_CHANNELS];

  logic                div_start, div_done;
  logic [RATIO_W-1:0]  div_dividend, div_quot;
  logic [DIV_W-1:0]    div_divisor;

  logic                    mac_en;
  logic signed [OPA_W-1:0] mac_a, mac_d;
  logic [F_W-1:0]          mac_f;
  logic signed [ACC_W-1:0] mac_res;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_addr;
  logic [PIX_W-1:0]  ram_rdata;

  logic       accept;
  logic       out_free;
  split_t     sx, sy;
  logic [CH_BITS-1:0] c_lt, c_rt, c_lb, c_rb;
  logic signed [ACC_W-1:0] rnd_sum;
  logic [CH_BITS-1:0] rnd;
  logic               last_ch;

  function automatic logic [ADDR_W-1:0] pix_addr(logic [POS_W-1:0] row, logic [POS_W-1:0] col);
    return ADDR_W'(ADDR_W'(row) * ADDR_W'(MAX_SOURCE_WIDTH)) + ADDR_W'(col);
  endfunction

  // register saturation before use
  always_comb begin
    sw_eff = (sw_q == '0) ? SW_W'(1) :
             (sw_q > SW_W'(MAX_SOURCE_WIDTH)) ? SW_W'(MAX_SOURCE_WIDTH) : sw_q;
    sh_eff = (sh_q == '0) ? SW_W'(1) :
             (sh_q > SW_W'(MAX_SOURCE_HEIGHT)) ? SW_W'(MAX_SOURCE_HEIGHT) : sh_q;
    nch_eff = (cc_q == '0) ? CC_W'(1) :
              (cc_q > CC_W'(MAX_CHANNELS)) ? CC_W'(MAX_CHANNELS) : cc_q;
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sw_q <= SW_W'(256);
      sh_q <= SW_W'(256);
      tw_q <= TW_W'(256);
      th_q <= TW_W'(256);
      cc_q <= CC_W'(3);
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_SOURCE_WIDTH:  sw_q <= cfg_wdata_i[SW_W-1:0];
        CFG_SOURCE_HEIGHT: sh_q <= cfg_wdata_i[SW_W-1:0];
        CFG_TARGET_WIDTH:  tw_q <= cfg_wdata_i[TW_W-1:0];
        CFG_TARGET_HEIGHT: th_q <= cfg_wdata_i[TW_W-1:0];
        CFG_CHANNEL_COUNT: cc_q <= cfg_wdata_i[CC_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_stall_o = !((state_q == S_IDLE) && !need_q && !cfg_we_i);
  assign accept     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  assign sx = split_coord(mac_res, sw_eff);
  assign sy = split_coord(mac_res, sh_eff);

  assign c_lt = lt_q[ch_q*CH_BITS +: CH_BITS];
  assign c_rt = rt_q[ch_q*CH_BITS +: CH_BITS];
  assign c_lb = lb_q[ch_q*CH_BITS +: CH_BITS];
  assign c_rb = rb_q[ch_q*CH_BITS +: CH_BITS];

  // round half up and clamp to the channel range
  always_comb begin
    rnd_sum = mac_res + (ACC_W'(1) <<< (2 * FRACTION_BITS - 1));
    if (mac_res[ACC_W-1]) begin
      rnd = '0;
    end else if (rnd_sum[ACC_W-1:2*FRACTION_BITS] > RND_W'(255)) begin
      rnd = CH_BITS'(255);
    end else begin
      rnd = rnd_sum[2*FRACTION_BITS +: CH_BITS];
    end
  end

  assign last_ch = (CC_W'(ch_q) + CC_W'(1)) == nch_eff;

  always_comb begin
    state_d   = state_q;
    need_d    = need_q || cfg_we_i;
    ratio_x_d = ratio_x_q;
    ratio_y_d = ratio_y_q;
    px_d      = px_q;
    py_d      = py_q;
    left_d    = left_q;
    right_d   = right_q;
    top_d     = top_q;
    bot_d     = bot_q;
    fx_d      = fx_q;
    fy_d      = fy_q;
    lt_d      = lt_q;
    rt_d      = rt_q;
    lb_d      = lb_q;
    rb_d      = rb_q;
    tl_d      = tl_q;
    ch_d      = ch_q;
    stat_d    = stat_q;
    res_ch_d  = res_ch_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_stat_d  = out_stat_q;
    out_ch_d    = out_ch_q;

    div_start    = 1'b0;
    div_dividend = RATIO_W'(sw_eff - SW_W'(1)) << FRACTION_BITS;
    div_divisor  = (tw_q > TW_W'(1)) ? tw_q - TW_W'(1) : DIV_W'(1);

    mac_en = 1'b0;
    mac_a  = '0;
    mac_d  = '0;
    mac_f  = '0;

    ram_we   = 1'b0;
    ram_addr = pix_addr(pos_y_i, pos_x_i);

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (operation_i == OP_WRITE) begin
            ram_we = (pos_x_i < POS_W'(sw_eff)) && (pos_y_i < POS_W'(sh_eff));
          end else begin
            px_d = pos_x_i;
            py_d = pos_y_i;
            ch_d = '0;
            for (int i = 0; i < MAX_CHANNELS; i++) begin
              res_ch_d[i] = '0;
            end
            if ((TW_W'(pos_x_i) >= tw_q) || (TW_W'(pos_y_i) >= th_q)) begin
              stat_d  = 1'b1;
              state_d = S_DONE;
            end else begin
              stat_d  = 1'b0;
              state_d = S_MULX;
            end
          end
        end else if (need_q && !cfg_we_i) begin
          need_d    = 1'b0;
          div_start = 1'b1;
          state_d   = S_DIVX;
        end
      end
      S_DIVX: begin
        if (div_done) begin
          ratio_x_d    = (tw_q > TW_W'(1)) ? div_quot : '0;
          div_start    = 1'b1;
          div_dividend = RATIO_W'(sh_eff - SW_W'(1)) << FRACTION_BITS;
          div_divisor  = (th_q > TW_W'(1)) ? th_q - TW_W'(1) : DIV_W'(1);
          state_d      = S_DIVY;
        end
      end
      S_DIVY: begin
        if (div_done) begin
          ratio_y_d = (th_q > TW_W'(1)) ? div_quot : '0;
          state_d   = S_IDLE;
        end
      end
      S_MULX: begin
        mac_en  = 1'b1;
        mac_d   = OPA_W'(ratio_x_q);
        mac_f   = F_W'(px_q);
        state_d = S_MULY;
      end
      S_MULY: begin
        mac_en  = 1'b1;
        mac_d   = OPA_W'(ratio_y_q);
        mac_f   = F_W'(py_q);
        left_d  = sx.lo;
        right_d = sx.hi;
        fx_d    = sx.frac;
        state_d = S_SPLIT;
      end
      S_SPLIT: begin
        top_d   = sy.lo;
        bot_d   = sy.hi;
        fy_d    = sy.frac;
        state_d = S_RD0;
      end
      S_RD0: begin
        ram_addr = pix_addr(POS_W'(top_q), POS_W'(left_q));
        state_d  = S_RD1;
      end
      S_RD1: begin
        ram_addr = pix_addr(POS_W'(top_q), POS_W'(right_q));
        lt_d     = ram_rdata;
        state_d  = S_RD2;
      end
      S_RD2: begin
        ram_addr = pix_addr(POS_W'(bot_q), POS_W'(left_q));
        rt_d     = ram_rdata;
        state_d  = S_RD3;
      end
      S_RD3: begin
        ram_addr = pix_addr(POS_W'(bot_q), POS_W'(right_q));
        lb_d     = ram_rdata;
        state_d  = S_RD4;
      end
      S_RD4: begin
        rb_d    = ram_rdata;
        state_d = S_H0;
      end
      S_H0: begin
        mac_en  = 1'b1;
        mac_a   = OPA_W'(c_lt);
        mac_d   = OPA_W'(c_rt) - OPA_W'(c_lt);
        mac_f   = F_W'(fx_q);
        state_d = S_H1;
      end
      S_H1: begin
        tl_d    = OPA_W'(mac_res);
        mac_en  = 1'b1;
        mac_a   = OPA_W'(c_lb);
        mac_d   = OPA_W'(c_rb) - OPA_W'(c_lb);
        mac_f   = F_W'(fx_q);
        state_d = S_V;
      end
      S_V: begin
        // mac holds the bottom row value here
        mac_en  = 1'b1;
        mac_a   = tl_q;
        mac_d   = OPA_W'(mac_res) - tl_q;
        mac_f   = F_W'(fy_q);
        state_d = S_VD;
      end
      S_VD: begin
        res_ch_d[ch_q] = rnd;
        if (last_ch) begin
          state_d = S_DONE;
        end else begin
          ch_d    = ch_q + CHI_W'(1);
          state_d = S_H0;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_stat_d  = stat_q;
          out_ch_d    = res_ch_q;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      need_q      <= 1'b1;
      ratio_x_q   <= '0;
      ratio_y_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      need_q      <= need_d;
      ratio_x_q   <= ratio_x_d;
      ratio_y_q   <= ratio_y_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    px_q       <= px_d;
    py_q       <= py_d;
    left_q     <= left_d;
    right_q    <= right_d;
    top_q      <= top_d;
    bot_q      <= bot_d;
    fx_q       <= fx_d;
    fy_q       <= fy_d;
    lt_q       <= lt_d;
    rt_q       <= rt_d;
    lb_q       <= lb_d;
    rb_q       <= rb_d;
    tl_q       <= tl_d;
    ch_q       <= ch_d;
    stat_q     <= stat_d;
    res_ch_q   <= res_ch_d;
    out_stat_q <= out_stat_d;
    out_ch_q   <= out_ch_d;
  end

  bir_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  bir_mac u_mac (
    .clk_i (clk_i),
    .en_i  (mac_en),
    .a_i   (mac_a),
    .d_i   (mac_d),
    .f_i   (mac_f),
    .res_o (mac_res)
  );

  bir_ram #(
    .Width (PIX_W),
    .Depth (MAX_SOURCE_WIDTH * MAX_SOURCE_HEIGHT)
  ) u_src_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i ({in_ch3_i, in_ch2_i, in_ch1_i, in_ch0_i}),
    .rdata_o (ram_rdata)
  );

  assign out_valid_o = out_valid_q;
  assign status_o    = out_stat_q;
  assign out_ch0_o   = out_ch_q[0];
  assign out_ch1_o   = out_ch_q[1];
  assign out_ch2_o   = out_ch_q[2];
  assign out_ch3_o   = out_ch_q[3];

endmodule
